// ----- rtl/dip_direction_to_rgb_color_assert.svh -----
// Assertion macros shared by the dip-to-color RTL.
// Users must have signals named clock and reset in scope.
`ifndef DIP_DIRECTION_TO_RGB_COLOR_ASSERT_SVH
`define DIP_DIRECTION_TO_RGB_COLOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DTRC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtrc: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DTRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtrc: assertion failed");

`endif

// ----- rtl/dtrc_pkg.sv -----
// Package for the dip/dip-direction to RGB color block.
// Holds widths, constants, register indexes and the payload structs; no dependencies.
package dtrc_pkg;

   localparam int ANGLE_FRAC_BITS = 6;

   localparam int DIP_W   = 13;
   localparam int DIR_W   = 15;
   localparam int CHAN_W  = 8;
   localparam int NORTH_W = 9;
   localparam int WIN_W   = 7;
   localparam int DEG_W   = 10;

   localparam int FULL_DEG = 360;
   localparam int HALF_DEG = 180;
   localparam int FULL     = FULL_DEG << ANGLE_FRAC_BITS;

   localparam int HUE_W  = $clog2(FULL);
   localparam int WINX_W = WIN_W + ANGLE_FRAC_BITS;
   localparam int SAT_W  = (DIP_W > WINX_W) ? DIP_W : WINX_W;
   localparam int DIR_QB = $clog2((1 << DIR_W) / FULL + 1);
   localparam int DIRX_W = HUE_W + DIR_QB + 1;
   localparam int H6_W   = HUE_W + 3;
   localparam int DEN_W  = SAT_W + HUE_W;
   localparam int V_W    = DEN_W + CHAN_W;

   localparam int NUM_SECTORS = 6;
   localparam int SECT_W      = 3;
   localparam int DIV_STEPS   = CHAN_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = NORTH_W;

   localparam logic [NORTH_W-1:0] NORTH_RESET = '0;
   localparam logic [WIN_W-1:0]   MIN_RESET   = '0;
   localparam logic [WIN_W-1:0]   MAX_RESET   = WIN_W'(90);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORTH_ANGLE = 3'd0,
      CSR_INVERT_HUE  = 3'd1,
      CSR_LOWER_HEMI  = 3'd2,
      CSR_STRETCH_MIN = 3'd3,
      CSR_STRETCH_MAX = 3'd4
   } csr_index_type;

   // Hue sectors of the six-sector conversion, in order around the wheel.
   typedef enum logic [SECT_W-1:0] {
      SECT_R_TO_Y = 3'd0,
      SECT_Y_TO_G = 3'd1,
      SECT_G_TO_C = 3'd2,
      SECT_C_TO_B = 3'd3,
      SECT_B_TO_M = 3'd4,
      SECT_M_TO_R = 3'd5
   } sector_type;

   typedef struct packed {
      logic [DIP_W-1:0] dip;
      logic [DIR_W-1:0] dip_dir;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [NORTH_W-1:0] north_angle;
      logic               invert_hue;
      logic               lower_hemisphere;
      logic [WIN_W-1:0]   stretch_min;
      logic [WIN_W-1:0]   stretch_max;
   } cfg_type;

   typedef struct packed {
      logic [SAT_W-1:0] sn;
      logic [SAT_W-1:0] sd;
      sector_type       sector;
      logic [HUE_W-1:0] r;
      logic [HUE_W-1:0] fr;
   } front_type;

   typedef struct packed {
      logic [V_W-1:0]   vq;
      logic [V_W-1:0]   vt;
      logic [V_W-1:0]   vp;
      logic [DEN_W-1:0] den;
      sector_type       sector;
   } mul_type;

   typedef struct packed {
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] t;
      logic [CHAN_W-1:0] p;
      sector_type        sector;
   } div_type;

endpackage

// ----- rtl/dtrc_front.sv -----
// Front stages: hue offset and wrap, hue inversion, saturation window and sector split.
// Four register stages with per-stage valid bits; depends on dtrc_pkg.
`include "dip_direction_to_rgb_color_assert.svh"

module dtrc_front import dtrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      up_valid,
   output logic      up_ready,
   input  req_type   up_data,
   output logic      ds_valid,
   input  logic      ds_ready,
   output front_type ds_data
);

   localparam int STAGES = 4;

   typedef struct packed {
      logic [HUE_W-1:0] dmod;
      logic [HUE_W-1:0] off;
      logic [SAT_W-1:0] sn;
      logic [SAT_W-1:0] sd;
   } s1_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sn;
      logic [SAT_W-1:0] sd;
   } s2_type;

   logic [STAGES-1:0] vld_ff, vld_in, en;
   s1_type    s1_ff, s1_in;
   s2_type    s2_ff, s2_in;
   s2_type    s3_ff, s3_in;
   front_type s4_ff, s4_in;

   logic [NORTH_W-1:0] na_mod;
   logic [DEG_W-1:0]   off_deg, off_red;
   logic [SAT_W-1:0]   lo, hi, dip_x;
   logic               in_win;
   logic [HUE_W:0]     sum;
   logic [H6_W-1:0]    h6, base;
   sector_type         sect;

   // Remove whole turns from the raw direction by conditional subtraction.
   function automatic logic [HUE_W-1:0] dir_reduce(input logic [DIR_W-1:0] dir);
      logic [DIRX_W-1:0] x;
      logic [DIRX_W-1:0] step;
      x = DIRX_W'(dir);
      for (int k = DIR_QB - 1; k >= 0; k--) begin
         step = DIRX_W'(FULL) << k;
         if (x >= step) begin
            x = x - step;
         end
      end
      return x[HUE_W-1:0];
   endfunction

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || ds_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? up_valid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   // Stage 1: direction reduction, hue offset and saturation window.
   always_comb begin
      na_mod = (cfg.north_angle >= NORTH_W'(FULL_DEG)) ?
               cfg.north_angle - NORTH_W'(FULL_DEG) : cfg.north_angle;
      off_deg = (cfg.lower_hemisphere ? DEG_W'(0) : DEG_W'(HALF_DEG))
              + DEG_W'(FULL_DEG) - DEG_W'(na_mod);
      off_red = (off_deg >= DEG_W'(FULL_DEG)) ? off_deg - DEG_W'(FULL_DEG) : off_deg;

      lo     = SAT_W'(cfg.stretch_min) << ANGLE_FRAC_BITS;
      hi     = SAT_W'(cfg.stretch_max) << ANGLE_FRAC_BITS;
      dip_x  = SAT_W'(up_data.dip);
      in_win = (cfg.stretch_max > cfg.stretch_min) && (dip_x >= lo) && (dip_x <= hi);

      s1_in.dmod = dir_reduce(up_data.dip_dir);
      s1_in.off  = HUE_W'(off_red) << ANGLE_FRAC_BITS;
      s1_in.sn   = in_win ? dip_x - lo : '0;
      s1_in.sd   = in_win ? hi - lo : SAT_W'(1);
   end

   // Stage 2: wrap the offset hue into one turn.
   always_comb begin
      sum = {1'b0, s1_ff.dmod} + {1'b0, s1_ff.off};
      s2_in.hue = (sum >= (HUE_W+1)'(FULL)) ? HUE_W'(sum - (HUE_W+1)'(FULL))
                                            : HUE_W'(sum);
      s2_in.sn  = s1_ff.sn;
      s2_in.sd  = s1_ff.sd;
   end

   // Stage 3: optional inversion; a hue of zero stays zero.
   always_comb begin
      s3_in = s2_ff;
      if (cfg.invert_hue && (s2_ff.hue != '0)) begin
         s3_in.hue = HUE_W'(FULL) - s2_ff.hue;
      end
   end

   // Stage 4: six times the hue, split into sector and remainder.
   always_comb begin
      h6   = (H6_W'(s3_ff.hue) << 2) + (H6_W'(s3_ff.hue) << 1);
      sect = SECT_R_TO_Y;
      base = '0;
      for (int k = 1; k < NUM_SECTORS; k++) begin
         if (h6 >= H6_W'(k * FULL)) begin
            sect = sector_type'(SECT_W'(k));
            base = H6_W'(k * FULL);
         end
      end
      s4_in.sn     = s3_ff.sn;
      s4_in.sd     = s3_ff.sd;
      s4_in.sector = sect;
      s4_in.r      = HUE_W'(h6 - base);
      s4_in.fr     = HUE_W'(FULL) - HUE_W'(h6 - base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
      if (en[1]) begin
         s2_ff <= s2_in;
      end
      if (en[2]) begin
         s3_ff <= s3_in;
      end
      if (en[3]) begin
         s4_ff <= s4_in;
      end
   end

   assign up_ready = en[0];
   assign ds_valid = vld_ff[STAGES-1];
   assign ds_data  = s4_ff;

   // Saturation never exceeds one, and the window width is never zero.
   `DTRC_ASSERT_IMPL(a_front_sat_bound, vld_ff[0], (s1_ff.sn <= s1_ff.sd) && (s1_ff.sd != '0))
   // The sector remainder stays inside one sector.
   `DTRC_ASSERT_IMPL(a_front_sector, vld_ff[3], (s4_ff.r < HUE_W'(FULL)) && (s4_ff.fr != '0))

endmodule

// ----- rtl/dtrc_mul.sv -----
// Product stages: scales the sector terms by saturation and forms 255 times each numerator.
// Three register stages with per-stage valid bits; depends on dtrc_pkg.
`include "dip_direction_to_rgb_color_assert.svh"

module dtrc_mul import dtrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   output logic      up_ready,
   input  front_type up_data,
   output logic      ds_valid,
   input  logic      ds_ready,
   output mul_type   ds_data
);

   localparam int STAGES = 3;

   typedef struct packed {
      logic [DEN_W-1:0] a_q;
      logic [DEN_W-1:0] a_t;
      logic [DEN_W-1:0] a_p;
      logic [DEN_W-1:0] den;
      sector_type       sector;
   } prod_type;

   logic [STAGES-1:0] vld_ff, vld_in, en;
   prod_type m1_ff, m1_in;
   prod_type m2_ff, m2_in;
   mul_type  m3_ff, m3_in;
   logic     terms_ok;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || ds_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? up_valid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   // Stage 1: saturation times each sector term, and the common denominator.
   always_comb begin
      m1_in.a_q    = DEN_W'(up_data.sn) * DEN_W'(up_data.r);
      m1_in.a_t    = DEN_W'(up_data.sn) * DEN_W'(up_data.fr);
      m1_in.a_p    = DEN_W'(up_data.sn) * DEN_W'(FULL);
      m1_in.den    = DEN_W'(up_data.sd) * DEN_W'(FULL);
      m1_in.sector = up_data.sector;
   end

   // Stage 2: numerators of one minus each scaled term.
   always_comb begin
      m2_in.a_q    = m1_ff.den - m1_ff.a_q;
      m2_in.a_t    = m1_ff.den - m1_ff.a_t;
      m2_in.a_p    = m1_ff.den - m1_ff.a_p;
      m2_in.den    = m1_ff.den;
      m2_in.sector = m1_ff.sector;
   end

   // Stage 3: 255 times each numerator, as a shift and a subtract.
   always_comb begin
      m3_in.vq     = (V_W'(m2_ff.a_q) << CHAN_W) - V_W'(m2_ff.a_q);
      m3_in.vt     = (V_W'(m2_ff.a_t) << CHAN_W) - V_W'(m2_ff.a_t);
      m3_in.vp     = (V_W'(m2_ff.a_p) << CHAN_W) - V_W'(m2_ff.a_p);
      m3_in.den    = m2_ff.den;
      m3_in.sector = m2_ff.sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m1_ff <= m1_in;
      end
      if (en[1]) begin
         m2_ff <= m2_in;
      end
      if (en[2]) begin
         m3_ff <= m3_in;
      end
   end

   assign up_ready = en[0];
   assign ds_valid = vld_ff[STAGES-1];
   assign ds_data  = m3_ff;

   assign terms_ok = (m1_ff.den != '0) && (m1_ff.a_q <= m1_ff.den)
                   && (m1_ff.a_t <= m1_ff.den) && (m1_ff.a_p <= m1_ff.den);

   // Every scaled term fits under the denominator, so no numerator wraps.
   `DTRC_ASSERT_IMPL(a_mul_terms, vld_ff[0], terms_ok)

endmodule

// ----- rtl/dtrc_div.sv -----
// Restoring divider pipeline: one quotient bit per stage for three channels in parallel.
// Eight register stages with per-stage valid bits; depends on dtrc_pkg.
`include "dip_direction_to_rgb_color_assert.svh"

module dtrc_div import dtrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  mul_type up_data,
   output logic    ds_valid,
   input  logic    ds_ready,
   output div_type ds_data
);

   typedef struct packed {
      logic [V_W-1:0]    rem_q;
      logic [V_W-1:0]    rem_t;
      logic [V_W-1:0]    rem_p;
      logic [CHAN_W-1:0] quo_q;
      logic [CHAN_W-1:0] quo_t;
      logic [CHAN_W-1:0] quo_p;
      logic [DEN_W-1:0]  den;
      sector_type        sector;
   } dstage_type;

   logic [DIV_STEPS-1:0] vld_ff, vld_in, en;
   dstage_type           st_ff  [DIV_STEPS];
   dstage_type           st_in  [DIV_STEPS];
   dstage_type           st_src [DIV_STEPS];
   logic [V_W-1:0]       last_den;
   logic                 rem_ok;

   // One restoring step: returns the quotient bit above the new remainder.
   function automatic logic [V_W:0] div_step(input logic [V_W-1:0] rem,
                                             input logic [V_W-1:0] dv);
      logic hit;
      hit = (rem >= dv);
      return {hit, hit ? rem - dv : rem};
   endfunction

   always_comb begin
      en[DIV_STEPS-1] = !vld_ff[DIV_STEPS-1] || ds_ready;
      for (int i = DIV_STEPS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? up_valid : vld_ff[0];
      for (int i = 1; i < DIV_STEPS; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_comb begin
      st_src[0].rem_q  = up_data.vq;
      st_src[0].rem_t  = up_data.vt;
      st_src[0].rem_p  = up_data.vp;
      st_src[0].quo_q  = '0;
      st_src[0].quo_t  = '0;
      st_src[0].quo_p  = '0;
      st_src[0].den    = up_data.den;
      st_src[0].sector = up_data.sector;
   end

   for (genvar j = 1; j < DIV_STEPS; j++) begin : g_src
      assign st_src[j] = st_ff[j-1];
   end

   // Stage j decides quotient bit DIV_STEPS-1-j against den shifted to that weight.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - j;
      logic [V_W-1:0] dv;
      logic [V_W:0]   rq, rt, rp;

      always_comb begin
         dv = V_W'(st_src[j].den) << BIT;
         rq = div_step(st_src[j].rem_q, dv);
         rt = div_step(st_src[j].rem_t, dv);
         rp = div_step(st_src[j].rem_p, dv);
         st_in[j]            = st_src[j];
         st_in[j].rem_q      = rq[V_W-1:0];
         st_in[j].rem_t      = rt[V_W-1:0];
         st_in[j].rem_p      = rp[V_W-1:0];
         st_in[j].quo_q[BIT] = rq[V_W];
         st_in[j].quo_t[BIT] = rt[V_W];
         st_in[j].quo_p[BIT] = rp[V_W];
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign up_ready       = en[0];
   assign ds_valid       = vld_ff[DIV_STEPS-1];
   assign ds_data.q      = st_ff[DIV_STEPS-1].quo_q;
   assign ds_data.t      = st_ff[DIV_STEPS-1].quo_t;
   assign ds_data.p      = st_ff[DIV_STEPS-1].quo_p;
   assign ds_data.sector = st_ff[DIV_STEPS-1].sector;

   assign last_den = V_W'(st_ff[DIV_STEPS-1].den);
   assign rem_ok   = (st_ff[DIV_STEPS-1].rem_q < last_den)
                   && (st_ff[DIV_STEPS-1].rem_t < last_den)
                   && (st_ff[DIV_STEPS-1].rem_p < last_den);

   // After the last step every remainder is below the divisor.
   `DTRC_ASSERT_IMPL(a_div_rem, vld_ff[DIV_STEPS-1], rem_ok)
   // A finished quotient that is held back keeps its value.
   `DTRC_ASSERT_NEXT(a_div_hold, vld_ff[DIV_STEPS-1] && !ds_ready, vld_ff[DIV_STEPS-1] && $stable(ds_data))

endmodule

// ----- rtl/dip_direction_to_rgb_color.sv -----
// Dip / dip direction to RGB color: top level with the register file and output stage.
// Instantiates dtrc_front, dtrc_mul and dtrc_div; depends on dtrc_pkg.
//
// Usage: each pixel enters on the req_ channel (dip and dip_dir in degrees with
// ANGLE_FRAC_BITS fraction bits) and leaves as one color on the rsp_ channel.
// Both channels transfer when valid and ready are high at a rising edge.
// The csr_ channel writes one register per transfer and is always ready; index 0 is
// the north angle, 1 hue inversion, 2 lower hemisphere, 3 and 4 the dip window.
// Registers are meant to change only while no pixel is in flight.
// From the req_ transfer to rsp_valid a pixel passes four front stages, three
// product stages, eight divider stages (one quotient bit each) and the output
// register. A new pixel is taken every cycle while the receiver does not stall,
// so throughput is one pixel per clock; the divider depth sets the latency.
// Every stage has its own valid bit, so when the receiver stalls the empty stages
// still fill and req_ready drops only once all sixteen stages hold a pixel.
// Reset is synchronous: it empties the pipeline and loads north angle 0, no
// inversion, lower hemisphere and a dip window of 0 to 90 degrees.

module dip_direction_to_rgb_color import dtrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      f_valid, f_ready, m_valid, m_ready, d_valid, d_ready;
   front_type f_data;
   mul_type   m_data;
   div_type   d_data;
   logic      out_en;
   logic      rsp_vld_ff, rsp_vld_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NORTH_ANGLE: cfg_in.north_angle      = csr_data[NORTH_W-1:0];
            CSR_INVERT_HUE:  cfg_in.invert_hue       = csr_data[0];
            CSR_LOWER_HEMI:  cfg_in.lower_hemisphere = csr_data[0];
            CSR_STRETCH_MIN: cfg_in.stretch_min      = csr_data[WIN_W-1:0];
            CSR_STRETCH_MAX: cfg_in.stretch_max      = csr_data[WIN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.north_angle      <= NORTH_RESET;
         cfg_ff.invert_hue       <= 1'b0;
         cfg_ff.lower_hemisphere <= 1'b1;
         cfg_ff.stretch_min      <= MIN_RESET;
         cfg_ff.stretch_max      <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .ds_valid (f_valid),
      .ds_ready (f_ready),
      .ds_data  (f_data)
   );

   dtrc_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .up_valid (f_valid),
      .up_ready (f_ready),
      .up_data  (f_data),
      .ds_valid (m_valid),
      .ds_ready (m_ready),
      .ds_data  (m_data)
   );

   dtrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (m_valid),
      .up_ready (m_ready),
      .up_data  (m_data),
      .ds_valid (d_valid),
      .ds_ready (d_ready),
      .ds_data  (d_data)
   );

   // Output stage: place the three channel values by hue sector.
   assign out_en  = !rsp_vld_ff || rsp_ready;
   assign d_ready = out_en;

   always_comb begin
      rsp_vld_in = out_en ? d_valid : rsp_vld_ff;
      case (d_data.sector)
         SECT_R_TO_Y: rsp_data_in = '{red: '1,       green: d_data.t, blue: d_data.p};
         SECT_Y_TO_G: rsp_data_in = '{red: d_data.q, green: '1,       blue: d_data.p};
         SECT_G_TO_C: rsp_data_in = '{red: d_data.p, green: '1,       blue: d_data.t};
         SECT_C_TO_B: rsp_data_in = '{red: d_data.p, green: d_data.q, blue: '1};
         SECT_B_TO_M: rsp_data_in = '{red: d_data.t, green: d_data.p, blue: '1};
         default:     rsp_data_in = '{red: '1,       green: d_data.p, blue: d_data.q};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dip_direction_to_rgb_color: random pixel traffic with
// bursty input, a stalling receiver and register changes between phases. Depends on dtrc_pkg.
module testbench;
   import dtrc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_STALL = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   req_type pending_pixels[$];
   rsp_type expected_colors[$];
   cfg_type color_cfg;
   int pixels_queued = 0;
   int pixels_taken = 0;
   int fail_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int cycle_count = 0;
   bit stall_request = 1'b0;
   int stall_left = 0;
   int ready_mode = 0;
   int mode_left = 0;

   dip_direction_to_rgb_color u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Color of one pixel under the current register values. Hue, saturation and the
   // sector fraction are exact rationals, so every channel is floor(255 * c).
   function automatic rsp_type color_of(req_type px);
      longint unsigned full, lo, hi, d, h6, sector, r, sn, sd, den, pv, qv, tv;
      rsp_type c;
      full = longint'(FULL_DEG) << ANGLE_FRAC_BITS;
      lo = longint'(color_cfg.stretch_min) << ANGLE_FRAC_BITS;
      hi = longint'(color_cfg.stretch_max) << ANGLE_FRAC_BITS;
      d = px.dip_dir;
      if (!color_cfg.lower_hemisphere)
         d += longint'(HALF_DEG) << ANGLE_FRAC_BITS;
      d += (FULL_DEG - (color_cfg.north_angle % FULL_DEG)) << ANGLE_FRAC_BITS;
      d %= full;
      if (color_cfg.invert_hue)
         d = (full - d) % full;
      if (color_cfg.stretch_max > color_cfg.stretch_min && px.dip >= lo && px.dip <= hi) begin
         sn = px.dip - lo;
         sd = hi - lo;
      end else begin
         sn = 0;
         sd = 1;
      end
      h6 = d * 6;
      sector = h6 / full;
      r = h6 % full;
      den = sd * full;
      pv = (((den - sn * full) * 255) / den) & 8'hFF;
      qv = (((den - sn * r) * 255) / den) & 8'hFF;
      tv = (((den - sn * (full - r)) * 255) / den) & 8'hFF;
      case (sector_type'(sector[SECT_W-1:0]))
         SECT_R_TO_Y: c = '{8'd255, tv[7:0], pv[7:0]};
         SECT_Y_TO_G: c = '{qv[7:0], 8'd255, pv[7:0]};
         SECT_G_TO_C: c = '{pv[7:0], 8'd255, tv[7:0]};
         SECT_C_TO_B: c = '{pv[7:0], qv[7:0], 8'd255};
         SECT_B_TO_M: c = '{tv[7:0], pv[7:0], 8'd255};
         default:     c = '{8'd255, pv[7:0], qv[7:0]};
      endcase
      return c;
   endfunction

   // Driver: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_colors.push_back(color_of(req_data));
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               req_data <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each transfer and stalls on a pattern that changes every so often.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("color transfer with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.red !== want.red) begin
                  $error("red mismatch: expected %0d, actual %0d", want.red, rsp_data.red);
                  fail_count++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green mismatch: expected %0d, actual %0d", want.green, rsp_data.green);
                  fail_count++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue mismatch: expected %0d, actual %0d", want.blue, rsp_data.blue);
                  fail_count++;
               end
            end
         end
         if (stall_request) begin
            stall_request = 1'b0;
            stall_left = LONG_STALL;
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 6) != 0);
               default: rsp_ready <= (cycle_count % 4 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_pixel(int dip, int dir);
      req_type px;
      px.dip = dip[DIP_W-1:0];
      px.dip_dir = dir[DIR_W-1:0];
      pending_pixels.push_back(px);
      pixels_queued++;
   endtask

   task automatic add_random_pixel();
      int dip, dir;
      dip = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5760) : $urandom_range(0, 8191);
      dir = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 23040) : $urandom_range(0, 32767);
      add_pixel(dip, dir);
   endtask

   // Holds the sender until every queued pixel has come back as a checked color.
   task automatic wait_all_colors();
      do @(posedge clock);
      while (pixels_taken != pixels_queued || expected_colors.size() != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NORTH_ANGLE: color_cfg.north_angle = val;
         CSR_INVERT_HUE:  color_cfg.invert_hue = val[0];
         CSR_LOWER_HEMI:  color_cfg.lower_hemisphere = val[0];
         CSR_STRETCH_MIN: color_cfg.stretch_min = val[WIN_W-1:0];
         default:         color_cfg.stretch_max = val[WIN_W-1:0];
      endcase
   endtask

   // The single-bit registers also get random upper data bits, which must be ignored.
   task automatic configure(int north, int inv, int lower, int lo, int hi);
      write_reg(CSR_NORTH_ANGLE, north[CSR_DATA_W-1:0]);
      write_reg(CSR_INVERT_HUE, {8'($urandom_range(0, 255)), inv[0]});
      write_reg(CSR_LOWER_HEMI, {8'($urandom_range(0, 255)), lower[0]});
      write_reg(CSR_STRETCH_MIN, {2'($urandom_range(0, 3)), lo[WIN_W-1:0]});
      write_reg(CSR_STRETCH_MAX, {2'($urandom_range(0, 3)), hi[WIN_W-1:0]});
   endtask

   // Pixels right on and just outside the dip window, plus a zero direction.
   task automatic add_window_edges();
      int lo, hi;
      lo = int'(color_cfg.stretch_min) << ANGLE_FRAC_BITS;
      hi = int'(color_cfg.stretch_max) << ANGLE_FRAC_BITS;
      add_pixel(lo, $urandom_range(0, 23040));
      add_pixel(hi, $urandom_range(0, 23040));
      if (lo > 0)
         add_pixel(lo - 1, $urandom_range(0, 23040));
      if (hi < 8191)
         add_pixel(hi + 1, $urandom_range(0, 23040));
      add_pixel($urandom_range(0, 5760), 0);
   endtask

   initial begin
      int north, inv, lower, lo, hi;
      color_cfg = '{NORTH_RESET, 1'b0, 1'b1, MIN_RESET, MAX_RESET};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: hue sector boundaries, full turn, direction and dip extremes.
      for (int k = 0; k <= 6; k++)
         add_pixel(5760, k * 3840);
      add_pixel(5760, 23039);
      add_pixel(5760, 32767);
      add_pixel(2880, 1);
      add_pixel(0, 5000);
      add_pixel(8191, 12000);
      add_pixel(8191, 32767);
      add_pixel(4000, 20000);
      add_pixel(5759, 23041);
      wait_all_colors();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: configure(360, 1, 0, 90, 0);
            1: configure(511, 0, 0, 45, 45);
            2: configure(359, 1, 1, 0, 127);
            3: configure(180, 0, 0, 127, 127);
            4: configure(1, 1, 0, 0, 1);
            default: begin
               north = $urandom_range(0, 511);
               inv = $urandom_range(0, 1);
               lower = $urandom_range(0, 1);
               if ($urandom_range(0, 9) < 7) begin
                  lo = $urandom_range(0, 89);
                  hi = $urandom_range(lo + 1, 90);
               end else begin
                  lo = $urandom_range(0, 127);
                  hi = $urandom_range(0, 127);
               end
               configure(north, inv, lower, lo, hi);
            end
         endcase
         add_window_edges();
         // In one phase the receiver holds off long enough for the pipeline to fill.
         if (phase == 2)
            stall_request = 1'b1;
         repeat (50) add_random_pixel();
         wait_all_colors();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
